@@ design/pcrw_pkg.sv @@
// ============================================================================
// pcrw_pkg
// Shared types, codes and lookups for the packet class counter / rate watch.
// ============================================================================
package pcrw_pkg;

  // counter width; reported values are the low 32 bits
  localparam int COUNT_WIDTH = 32;
  localparam int CMP_W       = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // IP protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // service ports
  localparam logic [15:0] PORT_FTP_DATA = 16'd20;
  localparam logic [15:0] PORT_FTP_CTRL = 16'd21;
  localparam logic [15:0] PORT_SSH      = 16'd22;
  localparam logic [15:0] PORT_DNS      = 16'd53;
  localparam logic [15:0] PORT_DHCP     = 16'd67;
  localparam logic [15:0] PORT_HTTP     = 16'd80;
  localparam logic [15:0] PORT_HTTPS    = 16'd443;

  // protocol counter memory
  localparam int NUM_PROTO = 5;
  localparam int PROTO_AW  = $clog2(NUM_PROTO);
  localparam logic [PROTO_AW-1:0] PA_ICMP  = 3'd0;
  localparam logic [PROTO_AW-1:0] PA_IGMP  = 3'd1;
  localparam logic [PROTO_AW-1:0] PA_TCP   = 3'd2;
  localparam logic [PROTO_AW-1:0] PA_UDP   = 3'd3;
  localparam logic [PROTO_AW-1:0] PA_OTHER = 3'd4;

  // service counter memory
  localparam int NUM_SVC = 6;
  localparam int SVC_AW  = $clog2(NUM_SVC);
  localparam logic [SVC_AW-1:0] SA_HTTP  = 3'd0;
  localparam logic [SVC_AW-1:0] SA_HTTPS = 3'd1;
  localparam logic [SVC_AW-1:0] SA_DNS   = 3'd2;
  localparam logic [SVC_AW-1:0] SA_DHCP  = 3'd3;
  localparam logic [SVC_AW-1:0] SA_SSH   = 3'd4;
  localparam logic [SVC_AW-1:0] SA_FTP   = 3'd5;

  // external counter indexes
  localparam logic [3:0] CI_TOTAL = 4'd0;
  localparam logic [3:0] CI_ICMP  = 4'd1;
  localparam logic [3:0] CI_OTHER = 4'd5;
  localparam logic [3:0] CI_HTTP  = 4'd6;
  localparam logic [3:0] CI_FTP   = 4'd11;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_TOTAL = 2'd1,
    RD_PROTO = 2'd2,
    RD_SVC   = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic              hit;
    logic [SVC_AW-1:0] addr;
  } svc_sel_t;

  // result beat, last field in the low bits
  typedef struct packed {
    logic [47:0] attacker_mac;
    logic [15:0] attacker_port;
    logic [31:0] attacker_addr;
    logic        attacker_valid;
    logic [31:0] peak_interval;
    logic [31:0] interval_count;
    logic [31:0] counter_value;
  } result_t;

  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_LW    = 2;

  function automatic svc_sel_t svc_lookup(logic [15:0] port);
    svc_sel_t s;
    s.hit  = 1'b1;
    s.addr = SA_HTTP;
    unique case (port)
      PORT_HTTP:     s.addr = SA_HTTP;
      PORT_HTTPS:    s.addr = SA_HTTPS;
      PORT_DNS:      s.addr = SA_DNS;
      PORT_DHCP:     s.addr = SA_DHCP;
      PORT_SSH:      s.addr = SA_SSH;
      PORT_FTP_DATA: s.addr = SA_FTP;
      PORT_FTP_CTRL: s.addr = SA_FTP;
      default:       s.hit  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

@@ design/packet_class_counter_rate_watch_unit.sv @@
// ============================================================================
// packet_class_counter_rate_watch_unit
// Packet class counters with per-interval rate watch and attacker capture.
// ============================================================================
// Takes one beat per clock while the result queue has room: a parsed packet
// header, an interval-end tick or a counter read (tuser selects), and returns
// exactly one result beat for each. A result passes the stage 1 registers
// and the result queue before it shows on the master side. The protocol and
// service counters live in two small synchronous RAMs with one read port
// each; every beat reads its entry on acceptance and a packet beat writes
// the incremented value back in the following cycle, with the previous write
// forwarded when consecutive beats hit the same counter. A three-deep result
// queue lets input keep flowing while the output side stalls; tready drops
// only when the queue plus the beat in the update stage fill it.
// rate_threshold is taken any time (cfg_ready is tied high) and should be
// written while idle.
// ============================================================================
module packet_class_counter_rate_watch_unit (
  input  logic         clk,
  input  logic         rst,
  // input beats
  input  logic         s_tvalid,
  output logic         s_tready,
  // ip_protocol[7:0], syn_flag[8], ack_flag[9], source_port[25:10],
  // dest_port[41:26], source_addr[73:42], source_mac[121:74],
  // counter_index[125:122], zero[127:126]
  input  logic [127:0] s_tdata,
  // command[1:0]
  input  logic [1:0]   s_tuser,
  // result beats
  output logic         m_tvalid,
  input  logic         m_tready,
  // counter_value[31:0], interval_count[63:32], peak_interval[95:64],
  // attacker_valid[96], attacker_addr[128:97], attacker_port[144:129],
  // attacker_mac[192:145], zero[199:193]
  output logic [199:0] m_tdata,
  // rate_threshold write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  localparam int PAW = pcrw_pkg::PROTO_AW;
  localparam int SAW = pcrw_pkg::SVC_AW;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [31:0] rate_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_threshold <= 32'd300;
    end else if (cfg_valid && cfg_ready) begin
      rate_threshold <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: decode accepted beat, issue counter reads
  // --------------------------------------------------------------------------
  logic           in_accept;
  pcrw_pkg::cmd_t in_cmd;
  logic [7:0]     in_proto;
  logic           in_syn;
  logic           in_ack;
  logic [15:0]    in_sport;
  logic [15:0]    in_dport;
  logic [31:0]    in_addr;
  logic [47:0]    in_mac;
  logic [3:0]     in_index;

  assign in_accept = s_tvalid && s_tready;
  assign in_cmd    = pcrw_pkg::cmd_t'(s_tuser);
  assign in_proto  = s_tdata[7:0];
  assign in_syn    = s_tdata[8];
  assign in_ack    = s_tdata[9];
  assign in_sport  = s_tdata[25:10];
  assign in_dport  = s_tdata[41:26];
  assign in_addr   = s_tdata[73:42];
  assign in_mac    = s_tdata[121:74];
  assign in_index  = s_tdata[125:122];

  logic [PAW-1:0]      d_proto_addr;
  logic [PAW-1:0]      d_proto_raddr;
  logic                d_proto_we;
  pcrw_pkg::svc_sel_t  d_svc;
  logic [SAW-1:0]      d_svc_raddr;
  logic                d_svc_we;
  pcrw_pkg::rd_sel_t   d_rd_sel;
  logic [PAW-1:0]      d_rd_proto;
  logic [SAW-1:0]      d_rd_svc;
  logic                d_capture;
  logic                is_packet;
  logic                is_tcp;
  logic                is_udp;

  always_comb begin
    is_packet = (in_cmd == pcrw_pkg::CMD_PACKET);
    is_tcp    = (in_proto == pcrw_pkg::PROTO_TCP);
    is_udp    = (in_proto == pcrw_pkg::PROTO_UDP);

    unique case (in_proto)
      pcrw_pkg::PROTO_ICMP: d_proto_addr = pcrw_pkg::PA_ICMP;
      pcrw_pkg::PROTO_IGMP: d_proto_addr = pcrw_pkg::PA_IGMP;
      pcrw_pkg::PROTO_TCP:  d_proto_addr = pcrw_pkg::PA_TCP;
      pcrw_pkg::PROTO_UDP:  d_proto_addr = pcrw_pkg::PA_UDP;
      default:              d_proto_addr = pcrw_pkg::PA_OTHER;
    endcase

    // service: TCP SYN uses dest port, else ACK the source port; also UDP DNS
    priority if (is_tcp && in_syn) begin
      d_svc = pcrw_pkg::svc_lookup(in_dport);
    end else if (is_tcp && in_ack) begin
      d_svc = pcrw_pkg::svc_lookup(in_sport);
    end else if (is_udp && in_dport == pcrw_pkg::PORT_DNS) begin
      d_svc = '{hit: 1'b1, addr: pcrw_pkg::SA_DNS};
    end else begin
      d_svc = '{hit: 1'b0, addr: pcrw_pkg::SA_HTTP};
    end

    d_rd_proto = PAW'(in_index - pcrw_pkg::CI_ICMP);
    d_rd_svc   = SAW'(in_index - pcrw_pkg::CI_HTTP);
    priority if (in_cmd != pcrw_pkg::CMD_READ) begin
      d_rd_sel = pcrw_pkg::RD_NONE;
    end else if (in_index == pcrw_pkg::CI_TOTAL) begin
      d_rd_sel = pcrw_pkg::RD_TOTAL;
    end else if (in_index <= pcrw_pkg::CI_OTHER) begin
      d_rd_sel = pcrw_pkg::RD_PROTO;
    end else if (in_index <= pcrw_pkg::CI_FTP) begin
      d_rd_sel = pcrw_pkg::RD_SVC;
    end else begin
      d_rd_sel = pcrw_pkg::RD_NONE;
    end

    d_proto_we    = is_packet;
    d_svc_we      = is_packet && d_svc.hit;
    d_proto_raddr = (d_rd_sel == pcrw_pkg::RD_PROTO) ? d_rd_proto : d_proto_addr;
    d_svc_raddr   = (d_rd_sel == pcrw_pkg::RD_SVC) ? d_rd_svc : d_svc.addr;
    d_capture     = is_packet && is_tcp &&
                    (in_dport == pcrw_pkg::PORT_HTTP ||
                     in_dport == pcrw_pkg::PORT_HTTPS ||
                     in_dport == pcrw_pkg::PORT_DNS);
  end

  // --------------------------------------------------------------------------
  // stage 1 registers
  // --------------------------------------------------------------------------
  logic              s1_valid;
  pcrw_pkg::cmd_t    s1_cmd;
  logic              s1_proto_we;
  logic [PAW-1:0]    s1_proto_addr;
  logic              s1_svc_we;
  logic [SAW-1:0]    s1_svc_addr;
  pcrw_pkg::rd_sel_t s1_rd_sel;
  logic              s1_capture;
  logic [15:0]       s1_dport;
  logic [31:0]       s1_addr;
  logic [47:0]       s1_mac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd        <= in_cmd;
      s1_proto_we   <= d_proto_we;
      s1_proto_addr <= d_proto_raddr;
      s1_svc_we     <= d_svc_we;
      s1_svc_addr   <= d_svc_raddr;
      s1_rd_sel     <= d_rd_sel;
      s1_capture    <= d_capture;
      s1_dport      <= in_dport;
      s1_addr       <= in_addr;
      s1_mac        <= in_mac;
    end
  end

  // --------------------------------------------------------------------------
  // counter memories
  // --------------------------------------------------------------------------
  logic                    proto_we;
  pcrw_pkg::count_t        proto_rdata;
  pcrw_pkg::count_t        proto_cur;
  pcrw_pkg::count_t        proto_wdata;
  logic                    svc_we;
  pcrw_pkg::count_t        svc_rdata;
  pcrw_pkg::count_t        svc_cur;
  pcrw_pkg::count_t        svc_wdata;

  pcrw_counter_ram #(
    .DEPTH (pcrw_pkg::NUM_PROTO),
    .WIDTH (pcrw_pkg::COUNT_WIDTH)
  ) u_proto_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (proto_we),
    .waddr (s1_proto_addr),
    .wdata (proto_wdata),
    .re    (in_accept),
    .raddr (d_proto_raddr),
    .rdata (proto_rdata)
  );

  pcrw_counter_ram #(
    .DEPTH (pcrw_pkg::NUM_SVC),
    .WIDTH (pcrw_pkg::COUNT_WIDTH)
  ) u_svc_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (svc_we),
    .waddr (s1_svc_addr),
    .wdata (svc_wdata),
    .re    (in_accept),
    .raddr (d_svc_raddr),
    .rdata (svc_rdata)
  );

  // last cycle's write, forwarded over the stale read of the same entry
  logic             pfw_valid;
  logic [PAW-1:0]   pfw_addr;
  pcrw_pkg::count_t pfw_data;
  logic             sfw_valid;
  logic [SAW-1:0]   sfw_addr;
  pcrw_pkg::count_t sfw_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pfw_valid <= 1'b0;
      sfw_valid <= 1'b0;
    end else begin
      pfw_valid <= proto_we;
      sfw_valid <= svc_we;
    end
  end

  always_ff @(posedge clk) begin
    pfw_addr <= s1_proto_addr;
    pfw_data <= proto_wdata;
    sfw_addr <= s1_svc_addr;
    sfw_data <= svc_wdata;
  end

  assign proto_cur   = (pfw_valid && pfw_addr == s1_proto_addr) ? pfw_data : proto_rdata;
  assign svc_cur     = (sfw_valid && sfw_addr == s1_svc_addr) ? sfw_data : svc_rdata;
  assign proto_wdata = proto_cur + pcrw_pkg::count_t'(1);
  assign svc_wdata   = svc_cur + pcrw_pkg::count_t'(1);
  assign proto_we    = s1_valid && s1_proto_we;
  assign svc_we      = s1_valid && s1_svc_we;

  // --------------------------------------------------------------------------
  // stage 1: scalar state update and result
  // --------------------------------------------------------------------------
  pcrw_pkg::count_t total_count, total_count_next;
  pcrw_pkg::count_t running_interval, running_interval_next;
  pcrw_pkg::count_t closed_interval, closed_interval_next;
  pcrw_pkg::count_t peak_count, peak_count_next;
  logic             attacker_seen, attacker_seen_next;
  logic [31:0]      attacker_ip, attacker_ip_next;
  logic [15:0]      attacker_port, attacker_port_next;
  logic [47:0]      attacker_mac, attacker_mac_next;
  pcrw_pkg::count_t read_value;
  logic             armed;
  pcrw_pkg::result_t result;

  always_comb begin
    total_count_next      = total_count;
    running_interval_next = running_interval;
    closed_interval_next  = closed_interval;
    peak_count_next       = peak_count;
    attacker_seen_next    = attacker_seen;
    attacker_ip_next      = attacker_ip;
    attacker_port_next    = attacker_port;
    attacker_mac_next     = attacker_mac;
    armed = pcrw_pkg::CMP_W'(closed_interval) > pcrw_pkg::CMP_W'(rate_threshold);

    if (s1_valid && s1_cmd == pcrw_pkg::CMD_PACKET) begin
      total_count_next      = total_count + pcrw_pkg::count_t'(1);
      running_interval_next = running_interval + pcrw_pkg::count_t'(1);
      if (s1_capture && armed) begin
        attacker_seen_next = 1'b1;
        attacker_ip_next   = s1_addr;
        attacker_port_next = s1_dport;
        attacker_mac_next  = s1_mac;
      end
    end
    if (s1_valid && s1_cmd == pcrw_pkg::CMD_TICK) begin
      closed_interval_next  = running_interval;
      running_interval_next = '0;
      if (peak_count < running_interval) begin
        peak_count_next = running_interval;
      end
    end

    unique case (s1_rd_sel)
      pcrw_pkg::RD_TOTAL: read_value = total_count;
      pcrw_pkg::RD_PROTO: read_value = proto_cur;
      pcrw_pkg::RD_SVC:   read_value = svc_cur;
      default:            read_value = '0;
    endcase

    result.counter_value  = 32'(read_value);
    result.interval_count = 32'(closed_interval_next);
    result.peak_interval  = 32'(peak_count_next);
    result.attacker_valid = attacker_seen_next;
    result.attacker_addr  = attacker_ip_next;
    result.attacker_port  = attacker_port_next;
    result.attacker_mac   = attacker_mac_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count      <= '0;
      running_interval <= '0;
      closed_interval  <= '0;
      peak_count       <= '0;
      attacker_seen    <= 1'b0;
      attacker_ip      <= '0;
      attacker_port    <= '0;
      attacker_mac     <= '0;
    end else begin
      total_count      <= total_count_next;
      running_interval <= running_interval_next;
      closed_interval  <= closed_interval_next;
      peak_count       <= peak_count_next;
      attacker_seen    <= attacker_seen_next;
      attacker_ip      <= attacker_ip_next;
      attacker_port    <= attacker_port_next;
      attacker_mac     <= attacker_mac_next;
    end
  end

  // --------------------------------------------------------------------------
  // result queue and output
  // --------------------------------------------------------------------------
  logic [pcrw_pkg::FIFO_LW-1:0] fifo_level;
  logic [pcrw_pkg::FIFO_LW:0]   occupancy;
  pcrw_pkg::result_t            head;

  pcrw_result_fifo u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid),
    .push_data  (result),
    .pop        (m_tvalid && m_tready),
    .head_valid (m_tvalid),
    .head       (head),
    .level      (fifo_level)
  );

  // a beat in stage 1 already holds a queue slot
  assign occupancy = {1'b0, fifo_level} + {{pcrw_pkg::FIFO_LW{1'b0}}, s1_valid};
  assign s_tready  = occupancy < (pcrw_pkg::FIFO_LW + 1)'(pcrw_pkg::FIFO_DEPTH);
  assign m_tdata   = {7'b0, head};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (pcrw_pkg::FIFO_LW + 1)'(pcrw_pkg::FIFO_DEPTH))
    else $error("result queue overcommitted");

  a_peak_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_cmd == pcrw_pkg::CMD_TICK) |=> (peak_count >= closed_interval))
    else $error("peak below closed interval after tick");

  a_svc_proto: assert property (@(posedge clk) disable iff (rst)
    svc_we |-> (s1_proto_addr == pcrw_pkg::PA_TCP || s1_proto_addr == pcrw_pkg::PA_UDP))
    else $error("service counted for non TCP/UDP packet");

  a_seen_sticky: assert property (@(posedge clk) disable iff (rst)
    !($fell(attacker_seen) && !$past(rst)))
    else $error("attacker record dropped without reset");

endmodule

@@ design/pcrw_counter_ram.sv @@
// ============================================================================
// pcrw_counter_ram
// Small counter memory: one write, one registered read; entries read as zero
// until first written after reset.
// ============================================================================
module pcrw_counter_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  // read before write on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= written[raddr] ? mem[raddr] : '0;
    end
  end

endmodule

@@ design/pcrw_result_fifo.sv @@
// ============================================================================
// pcrw_result_fifo
// Three-entry result queue between the update stage and the output port.
// ============================================================================
module pcrw_result_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  pcrw_pkg::result_t            push_data,
  input  logic                         pop,
  output logic                         head_valid,
  output pcrw_pkg::result_t            head,
  output logic [pcrw_pkg::FIFO_LW-1:0] level
);

  pcrw_pkg::result_t             slots [pcrw_pkg::FIFO_DEPTH];
  logic [pcrw_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [pcrw_pkg::FIFO_AW-1:0]  rd_ptr;

  localparam logic [pcrw_pkg::FIFO_AW-1:0] LAST = pcrw_pkg::FIFO_AW'(pcrw_pkg::FIFO_DEPTH - 1);

  assign head_valid = (level != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

@@ tb/sv/pcrw_result_checker.sv @@
// ============================================================================
// pcrw_result_checker
// Watches the input, result and threshold channels of the packet class
// counter unit. It predicts every result beat from the accepted input beats
// and compares the result beats field by field in arrival order.
// ============================================================================
module pcrw_result_checker
  import pcrw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [199:0] m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  output int           mismatches,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CNT   = 12;
  localparam int CNT_TOTAL = 0;
  localparam int CNT_ICMP  = 1;
  localparam int CNT_IGMP  = 2;
  localparam int CNT_TCP   = 3;
  localparam int CNT_UDP   = 4;
  localparam int CNT_OTHER = 5;
  localparam int CNT_HTTP  = 6;
  localparam int CNT_HTTPS = 7;
  localparam int CNT_DNS   = 8;
  localparam int CNT_DHCP  = 9;
  localparam int CNT_SSH   = 10;
  localparam int CNT_FTP   = 11;

  localparam logic [31:0] THRESHOLD_AT_RESET = 32'd300;

  // predicted block state
  count_t      class_cnt [NUM_CNT];
  count_t      running_cnt;
  count_t      closed_cnt;
  count_t      peak_cnt;
  logic [31:0] threshold;
  logic        atk_seen;
  logic [31:0] atk_addr;
  logic [15:0] atk_port;
  logic [47:0] atk_mac;

  result_t     expected_results [$];
  result_t     got;
  result_t     want;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] seen_val,
                             input logic [63:0] want_val);
    if (seen_val !== want_val)
      report_mismatch($sformatf("%s got %0h expected %0h", name, seen_val, want_val));
  endtask

  function automatic void bump_service(input logic [15:0] port);
    case (port)
      PORT_HTTP:                    class_cnt[CNT_HTTP]++;
      PORT_HTTPS:                   class_cnt[CNT_HTTPS]++;
      PORT_DNS:                     class_cnt[CNT_DNS]++;
      PORT_DHCP:                    class_cnt[CNT_DHCP]++;
      PORT_SSH:                     class_cnt[CNT_SSH]++;
      PORT_FTP_DATA, PORT_FTP_CTRL: class_cnt[CNT_FTP]++;
      default: ;
    endcase
  endfunction

  // applies one input beat to the predicted state, returns the result beat
  function automatic result_t next_counter_view(input logic [1:0] cmd_bits,
                                                input logic [127:0] beat);
    logic [7:0]  proto;
    logic        syn;
    logic        ack;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] addr;
    logic [47:0] mac;
    logic [3:0]  idx;
    result_t     r;
    proto = beat[7:0];
    syn   = beat[8];
    ack   = beat[9];
    sport = beat[25:10];
    dport = beat[41:26];
    addr  = beat[73:42];
    mac   = beat[121:74];
    idx   = beat[125:122];
    r     = '0;
    case (cmd_t'(cmd_bits))
      CMD_PACKET: begin
        class_cnt[CNT_TOTAL]++;
        running_cnt++;
        case (proto)
          PROTO_ICMP: class_cnt[CNT_ICMP]++;
          PROTO_IGMP: class_cnt[CNT_IGMP]++;
          PROTO_TCP: begin
            class_cnt[CNT_TCP]++;
            // capture ignores flags, uses the last closed interval
            if (closed_cnt > threshold &&
                (dport == PORT_HTTP || dport == PORT_HTTPS || dport == PORT_DNS)) begin
              atk_seen = 1'b1;
              atk_addr = addr;
              atk_port = dport;
              atk_mac  = mac;
            end
            if (syn)
              bump_service(dport);
            else if (ack)
              bump_service(sport);
          end
          PROTO_UDP: begin
            class_cnt[CNT_UDP]++;
            if (dport == PORT_DNS)
              class_cnt[CNT_DNS]++;
          end
          default: class_cnt[CNT_OTHER]++;
        endcase
      end
      CMD_TICK: begin
        closed_cnt  = running_cnt;
        running_cnt = '0;
        if (peak_cnt < closed_cnt)
          peak_cnt = closed_cnt;
      end
      CMD_READ: begin
        if (idx < NUM_CNT)
          r.counter_value = 32'(class_cnt[idx]);
      end
      default: ;
    endcase
    r.interval_count = 32'(closed_cnt);
    r.peak_interval  = 32'(peak_cnt);
    r.attacker_valid = atk_seen;
    r.attacker_addr  = atk_addr;
    r.attacker_port  = atk_port;
    r.attacker_mac   = atk_mac;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (class_cnt[i])
        class_cnt[i] = '0;
      running_cnt = '0;
      closed_cnt  = '0;
      peak_cnt    = '0;
      threshold   = THRESHOLD_AT_RESET;
      atk_seen    = 1'b0;
      atk_addr    = '0;
      atk_port    = '0;
      atk_mac     = '0;
      expected_results.delete();
    end else begin
      // results first: a beat leaving now belongs to an older input
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result beat %0h with nothing expected", m_tdata));
        end else begin
          want = expected_results.pop_front();
          got  = m_tdata[192:0];
          check_field("counter_value", 64'(got.counter_value), 64'(want.counter_value));
          check_field("interval_count", 64'(got.interval_count),
                      64'(want.interval_count));
          check_field("peak_interval", 64'(got.peak_interval), 64'(want.peak_interval));
          check_field("attacker_valid", 64'(got.attacker_valid),
                      64'(want.attacker_valid));
          check_field("attacker_addr", 64'(got.attacker_addr), 64'(want.attacker_addr));
          check_field("attacker_port", 64'(got.attacker_port), 64'(want.attacker_port));
          check_field("attacker_mac", 64'(got.attacker_mac), 64'(want.attacker_mac));
        end
      end
      if (cfg_valid && cfg_ready)
        threshold = cfg_data;
      if (s_tvalid && s_tready)
        expected_results.push_back(next_counter_view(s_tuser, s_tdata));
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/sv/tb_packet_class_counter_rate_watch_unit.sv @@
// ============================================================================
// tb_packet_class_counter_rate_watch_unit
// Drives headers, interval ticks and counter reads into the packet class
// counter unit under bursty input and a stalling result side, and walks the
// rate threshold through several settings so attacker capture both arms and
// stays off. A separate checker predicts and compares every result beat.
// ============================================================================
module tb_packet_class_counter_rate_watch_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pcrw_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;       // a little over the pipeline latency
  localparam int RUN_LIMIT_NS  = 3_000_000;

  // counter indexes past the last counter, which read as zero
  localparam logic [3:0] IDX_SPARE_LO = 4'd12;
  localparam logic [3:0] IDX_SPARE_HI = 4'd15;

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  proto;
    logic        syn;
    logic        ack;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] addr;
    logic [47:0] mac;
    logic [3:0]  idx;
  } beat_t;

  // result side modes: always ready, coin flip, one stall in four, long clogs
  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_COMB, SINK_CLOG} sink_mode_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [199:0] m_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;
  int           mismatches;
  int           pending;

  int           burst_left = 0;
  sink_mode_t   sink_mode  = SINK_OPEN;
  int           mode_left  = 0;
  int           hold_left  = 0;
  int           comb_phase = 0;
  logic         sink_level = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  packet_class_counter_rate_watch_unit uut (.*);

  pcrw_result_checker checker_i (.*);

  // --------------------------------------------------------------------------
  // Beat builders
  // --------------------------------------------------------------------------

  // every field random, so unused fields carry noise on ticks and reads
  function automatic beat_t rand_beat(input cmd_t cmd);
    beat_t b;
    b.cmd   = cmd;
    b.proto = 8'($urandom);
    b.syn   = 1'($urandom);
    b.ack   = 1'($urandom);
    b.sport = 16'($urandom);
    b.dport = 16'($urandom);
    b.addr  = $urandom;
    b.mac   = 48'({$urandom, $urandom});
    b.idx   = 4'($urandom);
    return b;
  endfunction

  function automatic beat_t header(input logic [7:0] proto, input logic syn,
                                   input logic ack, input logic [15:0] sport,
                                   input logic [15:0] dport, input logic [31:0] addr,
                                   input logic [47:0] mac);
    beat_t b;
    b       = rand_beat(CMD_PACKET);
    b.proto = proto;
    b.syn   = syn;
    b.ack   = ack;
    b.sport = sport;
    b.dport = dport;
    b.addr  = addr;
    b.mac   = mac;
    return b;
  endfunction

  function automatic beat_t read_of(input logic [3:0] idx);
    beat_t b;
    b     = rand_beat(CMD_READ);
    b.idx = idx;
    return b;
  endfunction

  function automatic logic [15:0] service_port();
    case ($urandom_range(0, 6))
      0:       return PORT_HTTP;
      1:       return PORT_HTTPS;
      2:       return PORT_DNS;
      3:       return PORT_DHCP;
      4:       return PORT_SSH;
      5:       return PORT_FTP_DATA;
      default: return PORT_FTP_CTRL;
    endcase
  endfunction

  // one beat inside an interval: mostly headers biased toward TCP/UDP and
  // service ports, some reads over all 16 indexes, a few unused commands
  function automatic beat_t filler_beat();
    beat_t b;
    int    roll;
    roll = $urandom_range(0, 99);
    if (roll < 86) begin
      b = rand_beat(CMD_PACKET);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: b.proto = PROTO_TCP;
        4, 5:       b.proto = PROTO_UDP;
        6:          b.proto = PROTO_ICMP;
        7:          b.proto = PROTO_IGMP;
        default: ;  // keep the random protocol byte
      endcase
      if ($urandom_range(0, 9) < 6)
        b.dport = service_port();
      if ($urandom_range(0, 9) < 6)
        b.sport = service_port();
    end else if (roll < 98) begin
      b = rand_beat(CMD_READ);
    end else begin
      b = rand_beat(CMD_NONE);
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: bursts of random length with an idle gap before each, so valid
  // is never dropped and raised in the same step. Now and then a long burst
  // gives a stretch with no idling at all.
  // --------------------------------------------------------------------------
  task automatic send_beat(input beat_t b);
    int gap;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= b.cmd;
    s_tdata  <= {2'b00, b.idx, b.mac, b.addr, b.dport, b.sport, b.ack, b.syn, b.proto};
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  // stop sending and wait until every expected result beat has come back;
  // status is sampled on the falling edge to stay clear of the checker update
  task automatic settle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One threshold setting: intervals of random length closed by a tick.
  // Lengths around the threshold make capture arm in some intervals only.
  task automatic run_phase(input logic [31:0] thr, input int budget,
                           input int len_lo, input int len_hi);
    int sent;
    int len;
    write_threshold(thr);
    sent = 0;
    while (sent < budget) begin
      len = $urandom_range(len_lo, len_hi);
      repeat (len) send_beat(filler_beat());
      send_beat(rand_beat(CMD_TICK));
      sent += len + 1;
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Result side stall pattern: a mode is held for a random stretch, then
  // another is picked, so stalls land on every phase of the pipeline.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (mode_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(24, 160);
    end
    mode_left--;
    case (sink_mode)
      SINK_OPEN: m_tready <= 1'b1;
      SINK_COIN: m_tready <= 1'($urandom);
      SINK_COMB: begin
        comb_phase = (comb_phase + 1) % 4;
        m_tready <= (comb_phase != 0);
      end
      SINK_CLOG: begin
        if (hold_left == 0) begin
          sink_level = ~sink_level;
          hold_left  = sink_level ? $urandom_range(1, 3) : $urandom_range(4, 16);
        end
        hold_left--;
        m_tready <= sink_level;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_PACKET;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with threshold zero, so one packet in the closed
    // interval is enough to arm capture.
    write_threshold('0);
    send_beat(read_of(CI_TOTAL));        // all counters zero after reset
    send_beat(read_of(IDX_SPARE_HI));    // index past the counters reads zero
    send_beat(header(PROTO_ICMP, 1'b0, 1'b0, '0, '0, '0, '0));
    send_beat(header(PROTO_IGMP, 1'b1, 1'b1, '1, '1, '1, '1));
    // SYN counts the destination port; no capture yet, closed interval is zero
    send_beat(header(PROTO_TCP, 1'b1, 1'b0, '1, PORT_HTTP, '0, '0));
    // ACK alone counts the source port
    send_beat(header(PROTO_TCP, 1'b0, 1'b1, PORT_HTTPS, '1, '1, '1));
    // SYN wins over ACK
    send_beat(header(PROTO_TCP, 1'b1, 1'b1, PORT_HTTP, PORT_SSH, '0, '1));
    // neither flag: no service count
    send_beat(header(PROTO_TCP, 1'b0, 1'b0, PORT_DNS, PORT_DNS, '1, '0));
    send_beat(header(PROTO_TCP, 1'b1, 1'b0, '0, PORT_FTP_DATA, '0, '0));
    send_beat(header(PROTO_TCP, 1'b0, 1'b1, PORT_FTP_CTRL, '0, '0, '0));
    send_beat(header(PROTO_TCP, 1'b1, 1'b0, '0, PORT_DHCP, '0, '0));
    send_beat(header(PROTO_UDP, 1'b1, 1'b1, PORT_HTTP, PORT_DNS, '0, '0));
    send_beat(header(PROTO_UDP, 1'b1, 1'b0, PORT_DNS, PORT_HTTP, '0, '0));
    send_beat(header('1, 1'b1, 1'b1, PORT_HTTP, PORT_HTTP, '0, '0));
    send_beat(header('0, 1'b0, 1'b0, '0, '0, '0, '0));
    send_beat(rand_beat(CMD_NONE));      // unused command changes nothing
    send_beat(rand_beat(CMD_TICK));      // closes a busy interval, sets the peak
    // capture armed: both latch, flags play no part
    send_beat(header(PROTO_TCP, 1'b0, 1'b0, '0, PORT_HTTPS, '1, '1));
    send_beat(header(PROTO_TCP, 1'b0, 1'b1, '1, PORT_DNS, '0, '0));
    send_beat(rand_beat(CMD_TICK));      // smaller interval, peak holds
    send_beat(rand_beat(CMD_TICK));      // empty interval
    send_beat(read_of(CI_HTTP));
    send_beat(read_of(CI_FTP));
    send_beat(read_of(IDX_SPARE_LO));
    settle();

    // Random part, one threshold setting per phase, extremes included.
    run_phase(32'd5, 260, 0, 14);
    run_phase('1, 200, 0, 40);           // never armed
    run_phase(32'd300, 500, 260, 340);   // the reset value, intervals around it
    run_phase(32'd1, 140, 0, 4);
    run_phase($urandom_range(0, 50), 150, 0, 60);

    // everything has come back; keep the clock running for any stray beat
    // before the verdict
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // hard stop in case a handshake never completes
  initial begin
    #RUN_LIMIT_NS;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
design/pcrw_pkg.sv
design/pcrw_counter_ram.sv
design/pcrw_result_fifo.sv
design/packet_class_counter_rate_watch_unit.sv
tb/sv/pcrw_result_checker.sv
tb/sv/tb_packet_class_counter_rate_watch_unit.sv
